// ===== rtl/core/fbt_pkg.sv =====
package fbt_pkg;

	localparam int TableEntries = 64;
	localparam int IdxW = $clog2(TableEntries);

	localparam logic [2:0] CMD_CHECK = 3'd0;
	localparam logic [2:0] CMD_ADD   = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_ARM   = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_IGNORED   = 3'd1;
	localparam logic [2:0] ST_REFRESHED = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_FLUSHED   = 3'd4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [15:0] BLOCK_TIME_RST = 16'd1000;
	localparam logic [0:0] REG_BLOCK_TIME = 1'd0;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        has_conn;
		logic        family;
		logic [7:0]  proto;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
	} in_item_t;

	typedef struct packed {
		logic       drop;
		logic [2:0] status;
	} out_item_t;

	typedef struct packed {
		logic [8:0]   pf;
		logic [31:0]  ports;
		logic [63:0]  shi;
		logic [63:0]  slo;
		logic [63:0]  dhi;
		logic [63:0]  dlo;
	} tuple_t;

	// chain token travelling cell to cell
	typedef struct packed {
		logic   hit;
		logic   free_seen;
	} chain_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic   write;
		logic   clear;
	} cell_ctl_t;

endpackage

// ===== rtl/core/fbt_cell.sv =====
module fbt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  fbt_pkg::tuple_t    key,
	input  fbt_pkg::cell_ctl_t ctl,
	input  fbt_pkg::chain_t    chain_in,
	output fbt_pkg::chain_t    chain_out
);

	logic            valid_q;
	fbt_pkg::tuple_t tup_q;
	logic            match;
	logic            take;

	assign match = valid_q && (tup_q == key);
	// first free cell along the chain takes the write
	assign take = ctl.write && !valid_q && !chain_in.free_seen;

	assign chain_out.hit       = chain_in.hit | match;
	assign chain_out.free_seen = chain_in.free_seen | !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tup_q <= key;
		end
	end

endmodule

// ===== rtl/core/fbt_chain.sv =====
module fbt_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  fbt_pkg::tuple_t    key,
	input  fbt_pkg::cell_ctl_t ctl,
	output fbt_pkg::chain_t    result
);

	fbt_pkg::chain_t link [fbt_pkg::TableEntries+1];

	assign link[0] = '0;

	for (genvar g = 0; g < fbt_pkg::TableEntries; g++) begin : g_cell
		fbt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.ctl      (ctl),
			.chain_in (link[g]),
			.chain_out(link[g+1])
		);
	end

	assign result = link[fbt_pkg::TableEntries];

endmodule

// ===== rtl/core/flow_block_table_unit.sv =====
// Flow blocklist: one command per transaction, one result per command. A
// command is registered, the row of table cells compares the registered
// tuple and the result is registered when the output is not stalled; a new
// command is not taken until the last one has left the compare stage.
// A result stalled at the output holds the next command in the compare
// stage, so the input stalls only once that stage is occupied.
// Entries are cleared at reset and on timer expiry; no sweep needed.
module flow_block_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fbt_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fbt_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [15:0] block_time_q;
	logic [7:0]  active_q;
	logic [15:0] remain_q;
	logic        armed_q;
	logic        busy_q;
	fbt_pkg::in_item_t  item_q;
	fbt_pkg::out_item_t res_q;
	logic        res_valid_q;

	fbt_pkg::tuple_t    key;
	fbt_pkg::cell_ctl_t ctl;
	fbt_pkg::chain_t    cres;
	logic        accept;
	logic        fire;
	logic        proto_ok;
	logic        expire;
	fbt_pkg::out_item_t res_d;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {fbt_pkg::REG_BLOCK_TIME, 1'b0}) ?
		{16'd0, block_time_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_time_q <= fbt_pkg::BLOCK_TIME_RST;
		end else if (psel && penable && pwrite &&
				paddr == {fbt_pkg::REG_BLOCK_TIME, 1'b0}) begin
			block_time_q <= pwdata[15:0];
		end
	end

	// one item in flight; it waits in the compare stage while a result is held
	assign in_stall = busy_q;
	assign accept = in_valid && !in_stall;
	assign fire = busy_q && !(res_valid_q && out_stall);

	assign key.pf    = {item_q.family, item_q.proto};
	assign key.ports = {item_q.src_port, item_q.dst_port};
	assign key.shi   = item_q.src_addr_hi;
	assign key.slo   = item_q.src_addr_lo;
	assign key.dhi   = item_q.dst_addr_hi;
	assign key.dlo   = item_q.dst_addr_lo;

	assign proto_ok = item_q.proto == fbt_pkg::PROTO_TCP ||
		item_q.proto == fbt_pkg::PROTO_UDP;
	assign expire = armed_q && remain_q <= 16'd1;

	always_comb begin
		res_d = '0;
		ctl   = '0;
		case (item_q.cmd)
			fbt_pkg::CMD_CHECK: begin
				res_d.drop = (active_q != 8'd0) && item_q.has_conn && cres.hit;
			end
			fbt_pkg::CMD_ADD: begin
				if (!proto_ok) begin
					res_d.status = fbt_pkg::ST_IGNORED;
				end else if (cres.hit) begin
					res_d.status = fbt_pkg::ST_REFRESHED;
				end else if (!cres.free_seen) begin
					res_d.status = fbt_pkg::ST_FULL;
				end else begin
					ctl.write = 1'b1;
				end
			end
			fbt_pkg::CMD_TICK: begin
				if (expire) begin
					res_d.status = fbt_pkg::ST_FLUSHED;
					ctl.clear = 1'b1;
				end
			end
			default: ;
		endcase
		if (!fire) ctl = '0;
	end

	fbt_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (key),
		.ctl   (ctl),
		.result(cres)
	);

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_data;
		if (fire) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			active_q    <= 8'd0;
			remain_q    <= 16'd0;
			armed_q     <= 1'b0;
		end else begin
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
			busy_q <= accept || (busy_q && !fire);
			if (fire) begin
				case (item_q.cmd)
					fbt_pkg::CMD_START: begin
						if (active_q != 8'hFF) active_q <= active_q + 8'd1;
					end
					fbt_pkg::CMD_ARM: begin
						remain_q <= block_time_q;
						armed_q  <= 1'b1;
					end
					fbt_pkg::CMD_TICK: begin
						if (expire) begin
							if (active_q != 8'd0) active_q <= active_q - 8'd1;
							armed_q  <= 1'b0;
							remain_q <= 16'd0;
						end else if (armed_q) begin
							remain_q <= remain_q - 16'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && res_valid_q && out_stall |=> busy_q) else $error("item lost");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_res_follow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q) else $error("result missing");
	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> remain_q == 16'd0) else $error("timer state");

endmodule

// ===== dv/flow_block_table_checker.sv =====
module flow_block_table_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  fbt_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  fbt_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import fbt_pkg::*;

	logic                      tbl_valid [TableEntries];
	tuple_t                    tbl_tuple [TableEntries];
	logic [7:0]                blocking_depth;
	logic [15:0]               flush_left;
	logic                      flush_armed;
	logic [15:0]               flush_period;
	out_item_t                 verdicts [$];

	function automatic tuple_t tuple_of(in_item_t it);
		tuple_t t;
		t.pf = {it.family, it.proto};
		t.ports = {it.src_port, it.dst_port};
		t.shi = it.src_addr_hi;
		t.slo = it.src_addr_lo;
		t.dhi = it.dst_addr_hi;
		t.dlo = it.dst_addr_lo;
		return t;
	endfunction

	function automatic bit tuple_listed(tuple_t t);
		for (int i = 0; i < TableEntries; i++)
			if (tbl_valid[i] && tbl_tuple[i] == t) return 1;
		return 0;
	endfunction

	task automatic filter_step(in_item_t it);
		out_item_t r;
		tuple_t t;
		bit placed;
		r = '0;
		t = tuple_of(it);
		case (it.cmd)
			CMD_CHECK: r.drop = blocking_depth != 0 && it.has_conn && tuple_listed(t);
			CMD_ADD: begin
				if (it.proto != PROTO_TCP && it.proto != PROTO_UDP) r.status = ST_IGNORED;
				else if (tuple_listed(t)) r.status = ST_REFRESHED;
				else begin
					placed = 0;
					for (int i = 0; i < TableEntries && !placed; i++)
						if (!tbl_valid[i]) begin
							tbl_valid[i] = 1;
							tbl_tuple[i] = t;
							placed = 1;
						end
					r.status = placed ? ST_DONE : ST_FULL;
				end
			end
			CMD_START: if (blocking_depth != 8'hff) blocking_depth++;
			CMD_ARM: begin
				flush_left = flush_period;
				flush_armed = 1;
			end
			CMD_TICK: if (flush_armed) begin
				if (flush_left <= 1) begin
					for (int i = 0; i < TableEntries; i++) tbl_valid[i] = 0;
					if (blocking_depth != 0) blocking_depth--;
					flush_armed = 0;
					flush_left = 0;
					r.status = ST_FLUSHED;
				end else flush_left--;
			end
			default: ;
		endcase
		verdicts.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < TableEntries; i++) tbl_valid[i] = 0;
			blocking_depth = 0;
			flush_left = 0;
			flush_armed = 0;
			flush_period = BLOCK_TIME_RST;
			verdicts.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					exp_r = verdicts.pop_front();
					if (out_data.drop !== exp_r.drop) begin
						$error("drop expected %0d actual %0d", exp_r.drop, out_data.drop);
						fail_count++;
					end
					if (out_data.status !== exp_r.status) begin
						$error("status expected %0d actual %0d", exp_r.status,
							out_data.status);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) filter_step(in_data);
			if (psel && penable && pwrite && pready && paddr == 2'(REG_BLOCK_TIME) * 4)
				flush_period = pwdata[15:0];
		end
		pending_count = verdicts.size();
	end
endmodule

// ===== dv/flow_block_table_unit_test.sv =====
module flow_block_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fbt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending_count;
	int quiet_cycles = 0;
	bit calm_phase = 0;
	bit hold_recv = 0;
	in_item_t pool [$];

	always #5 clk = ~clk;

	flow_block_table_unit uut (.*);
	flow_block_table_checker chk (.*);

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("[flow_block_table_unit] ERROR");
			$finish;
		end
	end

	// receiver stalls in bursts, or a long hold when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_recv) begin
				out_stall <= 1;
				repeat (60) @(posedge clk);
				hold_recv = 0;
			end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	function automatic in_item_t random_tuple();
		in_item_t it;
		it = '0;
		it.has_conn = $urandom_range(0, 1);
		it.family = $urandom_range(0, 1);
		it.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		if ($urandom_range(0, 9) == 0) it.proto = $urandom_range(0, 255);
		it.src_port = $urandom;
		it.dst_port = $urandom;
		it.src_addr_hi = {$urandom, $urandom};
		it.src_addr_lo = {$urandom, $urandom};
		it.dst_addr_hi = {$urandom, $urandom};
		it.dst_addr_lo = {$urandom, $urandom};
		if (!it.family && $urandom_range(0, 3) != 0) begin
			it.src_addr_hi = '0;
			it.dst_addr_hi = '0;
		end
		return it;
	endfunction

	task automatic send(in_item_t it);
		int n;
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 9);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_cmd(logic [2:0] c);
		in_item_t it;
		it = random_tuple();
		it.cmd = c;
		send(it);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_block_time(logic [15:0] v);
		psel <= 1;
		pwrite <= 1;
		paddr <= 2'(REG_BLOCK_TIME) * 4;
		pwdata <= {16'(~v), v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	initial begin
		in_item_t it;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, unknown commands, full table, expiry
		write_block_time(16'd2);
		it = '1;
		it.cmd = CMD_ADD;
		it.proto = PROTO_UDP;
		send(it);
		it.cmd = CMD_CHECK;
		send(it);
		send_cmd(CMD_START);
		send(it);
		it.has_conn = 0;
		send(it);
		it = '0;
		it.cmd = CMD_ADD;
		it.proto = PROTO_TCP;
		send(it);
		send(it);
		it.proto = 8'hff;
		send(it);
		it.cmd = CMD_CHECK;
		it.has_conn = 1;
		it.proto = PROTO_TCP;
		send(it);
		for (int c = 5; c < 8; c++) send_cmd(3'(c));
		send_cmd(CMD_TICK);
		send_cmd(CMD_ARM);
		send_cmd(CMD_TICK);
		send_cmd(CMD_TICK);
		send(it);
		drain();
		write_block_time(16'd0);
		send_cmd(CMD_ARM);
		send_cmd(CMD_TICK);
		drain();
		write_block_time(16'hffff);
		for (int i = 0; i < TableEntries + 2; i++) send_cmd(CMD_ADD);
		send_cmd(CMD_START);
		for (int i = 0; i < 260; i++) begin
			it.cmd = CMD_START;
			send(it);
		end
		drain();

		// random: add/check sequences reusing stored tuples, timer activity
		for (int p = 0; p < 4; p++) begin
			write_block_time(p == 3 ? 16'd1 : 16'($urandom_range(1, 12)));
			if (p == 1) hold_recv = 1;
			if (p == 3) calm_phase = 1;
			for (int i = 0; i < 75; i++) begin
				r = $urandom_range(0, 99);
				if (r < 30 || pool.size() == 0) begin
					it = random_tuple();
					it.cmd = CMD_ADD;
					pool.push_back(it);
					if (pool.size() > 40) void'(pool.pop_front());
				end else if (r < 70) begin
					it = pool[$urandom_range(0, pool.size() - 1)];
					it.cmd = $urandom_range(0, 3) == 0 ? CMD_ADD : CMD_CHECK;
					it.has_conn = $urandom_range(0, 5) != 0;
					if ($urandom_range(0, 5) == 0) it.src_addr_lo[$urandom_range(0, 63)] ^= 1;
				end else if (r < 78) begin
					it = random_tuple();
					it.cmd = CMD_CHECK;
				end else if (r < 84) begin
					it = random_tuple();
					it.cmd = CMD_START;
				end else if (r < 88) begin
					it = random_tuple();
					it.cmd = CMD_ARM;
				end else if (r < 98) begin
					it = random_tuple();
					it.cmd = CMD_TICK;
				end else begin
					it = random_tuple();
					it.cmd = 3'($urandom_range(5, 7));
				end
				send(it);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[flow_block_table_unit] OK");
		else
			$display("[flow_block_table_unit] ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/fbt_pkg.sv
rtl/core/fbt_cell.sv
rtl/core/fbt_chain.sv
rtl/core/flow_block_table_unit.sv
dv/flow_block_table_checker.sv
dv/flow_block_table_unit_test.sv
